// File: design/raycast_wall_column_setup_macros.svh
`ifndef RAYCAST_WALL_COLUMN_SETUP_MACROS_SVH
`define RAYCAST_WALL_COLUMN_SETUP_MACROS_SVH

// same-cycle implication, off during reset
`define RWCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raycast wall column setup check failed");

// next-cycle implication, off during reset
`define RWCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raycast wall column setup check failed");

// next-cycle implication, checked through reset as well
`define RWCS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("raycast wall column setup reset check failed");

`endif

// File: design/rwcs_pkg.sv
package rwcs_pkg;

  localparam int SCREEN_HEIGHT = 480;
  localparam int MAX_TEX_DIM   = 4096;
  localparam int MID_ROW       = SCREEN_HEIGHT / 2;
  localparam int NUM_REGS      = 8;

  // pipelined divider geometry
  localparam int DIV_NW = 29;
  localparam int DIV_DW = 24;

  localparam logic [DIV_NW-1:0] HEIGHT_NUM = DIV_NW'(SCREEN_HEIGHT * 65536);

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_t;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > 13'(MAX_TEX_DIM)) begin
      r = 13'(MAX_TEX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  typedef struct packed {
    logic [10:0] column;
    face_t       face;
    logic [12:0] th;
    logic        dist_zero;
    logic [11:0] tx;
  } sb_a_t;

  typedef struct packed {
    logic [10:0] column;
    face_t       face;
    logic [15:0] height;
    logic [8:0]  first_row;
    logic [8:0]  stop_row;
    logic [11:0] tx;
    logic [16:0] a2;
  } sb_b_t;

endpackage

// File: design/raycast_wall_column_setup.sv
// throughput: one item per cycle; two 29-stage pipelined dividers (height, then
// texture step) plus five setup stages, all advancing together on one enable
// a stall at the output holds every stage in place
// reset (rst_n low, synchronous): all valid bits cleared, texture sizes set to 64
module raycast_wall_column_setup (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // column[10:0] hit_side[11] wall_distance[35:12] dir_x[51:36] dir_y[67:52]
  // player_x[91:68] player_y[115:92], zero pad to 120
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // column_out[10:0] face_texture[12:11] line_height[28:13] first_row[37:29]
  // stop_row[46:38] texel_column[58:47] texel_step[90:59] texel_start[130:91],
  // zero pad to 136
  output logic [135:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  localparam int NW = rwcs_pkg::DIV_NW;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // texture size registers
  logic [12:0] cfg_regs_r [rwcs_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rwcs_pkg::NUM_REGS; i++) begin
        cfg_regs_r[i] <= 13'd64;
      end
    end else if (cfg_valid && (cfg_index < 4'(rwcs_pkg::NUM_REGS))) begin
      cfg_regs_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // input unpack
  logic [10:0]        i_column;
  logic               i_side;
  logic [23:0]        i_dist;
  logic signed [15:0] i_dir_x;
  logic signed [15:0] i_dir_y;
  logic [23:0]        i_px;
  logic [23:0]        i_py;
  rwcs_pkg::face_t    i_face;
  logic [12:0]        i_tw;

  assign i_column = in_tdata[10:0];
  assign i_side   = in_tdata[11];
  assign i_dist   = in_tdata[35:12];
  assign i_dir_x  = $signed(in_tdata[51:36]);
  assign i_dir_y  = $signed(in_tdata[67:52]);
  assign i_px     = in_tdata[91:68];
  assign i_py     = in_tdata[115:92];

  always_comb begin
    if (!i_side) begin
      i_face = (i_dir_x > 16'sd0) ? rwcs_pkg::FACE_EAST : rwcs_pkg::FACE_WEST;
    end else begin
      i_face = (i_dir_y > 16'sd0) ? rwcs_pkg::FACE_SOUTH : rwcs_pkg::FACE_NORTH;
    end
  end

  assign i_tw = rwcs_pkg::clamp_dim(cfg_regs_r[{i_face, 1'b0}]);

  // stage 1: face and texture sizes
  logic               s1_vld_r;
  logic [10:0]        s1_column_r;
  logic               s1_side_r;
  logic [23:0]        s1_dist_r;
  logic signed [15:0] s1_dir_r;
  logic [15:0]        s1_pos_r;
  rwcs_pkg::face_t    s1_face_r;
  logic [11:0]        s1_twm1_r;
  logic [12:0]        s1_th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
    if (en) begin
      s1_column_r <= i_column;
      s1_side_r   <= i_side;
      s1_dist_r   <= i_dist;
      s1_dir_r    <= i_side ? i_dir_x : i_dir_y;
      s1_pos_r    <= i_side ? i_px[15:0] : i_py[15:0];
      s1_face_r   <= i_face;
      s1_twm1_r   <= 12'(i_tw - 13'd1);
      s1_th_r     <= rwcs_pkg::clamp_dim(cfg_regs_r[{i_face, 1'b1}]);
    end
  end

  // stage 2: hit coordinate fraction in q0.30
  logic signed [40:0] hit_prod;
  logic [29:0]        hit30;

  assign hit_prod = $signed({1'b0, s1_dist_r}) * s1_dir_r;
  assign hit30    = hit_prod[29:0] + {s1_pos_r, 14'd0};

  logic            s2_vld_r;
  logic [10:0]     s2_column_r;
  logic            s2_side_r;
  logic [23:0]     s2_dist_r;
  rwcs_pkg::face_t s2_face_r;
  logic [11:0]     s2_twm1_r;
  logic [12:0]     s2_th_r;
  logic [29:0]     s2_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_column_r <= s1_column_r;
      s2_side_r   <= s1_side_r;
      s2_dist_r   <= s1_dist_r;
      s2_face_r   <= s1_face_r;
      s2_twm1_r   <= s1_twm1_r;
      s2_th_r     <= s1_th_r;
      s2_frac_r   <= hit30;
    end
  end

  // stage 3: texel column, mirrored on y sides
  logic [30:0] tx_term;
  logic [42:0] tx_prod;

  assign tx_term = s2_side_r ? (31'h4000_0000 - {1'b0, s2_frac_r}) : {1'b0, s2_frac_r};
  assign tx_prod = tx_term * s2_twm1_r;

  logic            s3_vld_r;
  rwcs_pkg::sb_a_t s3_sb_r;
  logic [23:0]     s3_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      s3_sb_r.column    <= s2_column_r;
      s3_sb_r.face      <= s2_face_r;
      s3_sb_r.th        <= s2_th_r;
      s3_sb_r.dist_zero <= (s2_dist_r == 24'd0);
      s3_sb_r.tx        <= tx_prod[41:30];
      s3_dist_r         <= s2_dist_r;
    end
  end

  // height divider with matching side line
  logic                 da_vld;
  logic [NW-1:0]        da_quo;
  rwcs_pkg::sb_a_t      sba_r [NW];

  rwcs_div u_div_height (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s3_vld_r),
    .num     (rwcs_pkg::HEIGHT_NUM),
    .den     (s3_dist_r),
    .out_vld (da_vld),
    .quo     (da_quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sba_r[0] <= s3_sb_r;
      for (int k = 1; k < NW; k++) begin
        sba_r[k] <= sba_r[k-1];
      end
    end
  end

  // stage 4: height, row span, start offset
  rwcs_pkg::sb_a_t  da_sb;
  logic [15:0]      height;
  logic [14:0]      half;
  logic [8:0]       row_first;
  logic [16:0]      stop_sum;
  logic [8:0]       row_stop;
  logic signed [18:0] a2;

  assign da_sb = sba_r[NW-1];

  always_comb begin
    if (da_sb.dist_zero || (da_quo > NW'(16'hFFFF))) begin
      height = 16'hFFFF;
    end else begin
      height = da_quo[15:0];
    end
    half = height[15:1];
    if ({1'b0, half} >= 16'(rwcs_pkg::MID_ROW)) begin
      row_first = 9'd0;
    end else begin
      row_first = 9'(16'(rwcs_pkg::MID_ROW) - {1'b0, half});
    end
    stop_sum = 17'(rwcs_pkg::MID_ROW) + {2'b0, half};
    if (stop_sum >= 17'(rwcs_pkg::SCREEN_HEIGHT)) begin
      row_stop = 9'(rwcs_pkg::SCREEN_HEIGHT - 1);
    end else begin
      row_stop = stop_sum[8:0];
    end
    a2 = $signed({9'd0, row_first, 1'b0}) + $signed({3'd0, height})
         - $signed(19'(rwcs_pkg::SCREEN_HEIGHT));
  end

  logic            s4_vld_r;
  rwcs_pkg::sb_b_t s4_sb_r;
  logic [12:0]     s4_th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= da_vld;
    end
    if (en) begin
      s4_sb_r.column    <= da_sb.column;
      s4_sb_r.face      <= da_sb.face;
      s4_sb_r.height    <= height;
      s4_sb_r.first_row <= row_first;
      s4_sb_r.stop_row  <= row_stop;
      s4_sb_r.tx        <= da_sb.tx;
      s4_sb_r.a2        <= (a2 > 19'sd0) ? a2[16:0] : 17'd0;
      s4_th_r           <= da_sb.th;
    end
  end

  // texture step divider
  logic            db_vld;
  logic [NW-1:0]   db_quo;
  rwcs_pkg::sb_b_t sbb_r [NW];

  rwcs_div u_div_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s4_vld_r),
    .num     ({s4_th_r, 16'd0}),
    .den     ({8'd0, s4_sb_r.height}),
    .out_vld (db_vld),
    .quo     (db_quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbb_r[0] <= s4_sb_r;
      for (int k = 1; k < NW; k++) begin
        sbb_r[k] <= sbb_r[k-1];
      end
    end
  end

  // stage 5: step saturation and start product
  rwcs_pkg::sb_b_t db_sb;
  logic [31:0]     step;

  assign db_sb = sbb_r[NW-1];
  assign step  = (db_sb.height == 16'd0) ? 32'hFFFF_FFFF : 32'(db_quo);

  logic            s5_vld_r;
  rwcs_pkg::sb_b_t s5_sb_r;
  logic [31:0]     s5_step_r;
  logic [48:0]     s5_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= db_vld;
    end
    if (en) begin
      s5_sb_r   <= db_sb;
      s5_step_r <= step;
      s5_prod_r <= db_sb.a2 * step;
    end
  end

  // output register
  logic [39:0]  start_pos;
  logic         out_vld_r;
  logic [135:0] out_data_r;

  assign start_pos = (s5_prod_r[48:41] != 8'd0) ? 40'hFF_FFFF_FFFF : s5_prod_r[40:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s5_vld_r;
    end
    if (en) begin
      out_data_r <= {5'd0, start_pos, s5_step_r, s5_sb_r.tx, s5_sb_r.stop_row,
                     s5_sb_r.first_row, s5_sb_r.height, s5_sb_r.face, s5_sb_r.column};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/rwcs_div.sv
module rwcs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [rwcs_pkg::DIV_NW-1:0]   num,
  input  logic [rwcs_pkg::DIV_DW-1:0]   den,
  output logic                          out_vld,
  output logic [rwcs_pkg::DIV_NW-1:0]   quo
);

  localparam int NW = rwcs_pkg::DIV_NW;
  localparam int DW = rwcs_pkg::DIV_DW;

  logic          vld_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] den_r [NW];

  logic          vld_nxt [NW];
  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [NW-1:0] quo_nxt [NW];
  logic [DW-1:0] den_nxt [NW];

  // one restoring step per stage, msb first
  always_comb begin
    logic          s_vld;
    logic [DW-1:0] s_rem;
    logic [NW-1:0] s_num;
    logic [NW-1:0] s_quo;
    logic [DW-1:0] s_den;
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic          ge;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        s_vld = in_vld;
        s_rem = '0;
        s_num = num;
        s_quo = '0;
        s_den = den;
      end else begin
        s_vld = vld_r[k-1];
        s_rem = rem_r[k-1];
        s_num = num_r[k-1];
        s_quo = quo_r[k-1];
        s_den = den_r[k-1];
      end
      part = {s_rem, s_num[NW-1]};
      diff = part - {1'b0, s_den};
      ge   = (part >= {1'b0, s_den});
      vld_nxt[k] = s_vld;
      rem_nxt[k] = ge ? diff[DW-1:0] : part[DW-1:0];
      num_nxt[k] = {s_num[NW-2:0], 1'b0};
      quo_nxt[k] = {s_quo[NW-2:0], ge};
      den_nxt[k] = s_den;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (en) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign quo     = quo_r[NW-1];

endmodule

// File: design/rwcs_checker.sv
`include "raycast_wall_column_setup_macros.svh"

module rwcs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  // a stalled result stays and holds its bits
  `RWCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // drawn span never inverts
  `RWCS_ASSERT_NOW(a_row_order, out_tvalid, out_tdata[37:29] <= out_tdata[46:38])

  // stop row stays on screen
  `RWCS_ASSERT_NOW(a_stop_range, out_tvalid, out_tdata[46:38] < 9'(rwcs_pkg::SCREEN_HEIGHT))

  // reset empties the pipeline
  `RWCS_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind raycast_wall_column_setup rwcs_checker u_rwcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
